// File: hw/rtl/first_fit_block_allocator_core_defines.svh
// ---------------------------------------------------------------------------
// First-fit block allocator assertion macros
// Shared concurrent assertion forms for the allocator checker.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define FFBA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/ffba_pkg.sv
// ---------------------------------------------------------------------------
// First-fit block allocator package
// Sizes, request and status codes, and the types shared by the cell row.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 32;

    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int DATA_W = 32;
    localparam int END_W  = DATA_W + 2;

    localparam logic [DATA_W-1:0] HEAP_LIMIT_RST = 32'd1048576;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_REALLOC = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic              vld;
        logic              fit_hit;
        logic [IDX_W-1:0]  fit_idx;
        logic [DATA_W-1:0] fit_addr;
        logic              lk_hit;
        logic [IDX_W-1:0]  lk_idx;
        logic              lk_free;
        logic [DATA_W-1:0] lk_size;
    } t_ffba_tok;

    typedef struct packed {
        logic              app_en;
        logic [IDX_W-1:0]  app_idx;
        logic [DATA_W-1:0] app_addr;
        logic [DATA_W-1:0] app_size;
        logic              clr_en;
        logic [IDX_W-1:0]  clr_idx;
        logic              set_en;
        logic [IDX_W-1:0]  set_idx;
    } t_ffba_upd;

endpackage

// File: hw/rtl/ffba_cell.sv
// ---------------------------------------------------------------------------
// First-fit block allocator cell
// Holds one block entry and passes the search item on to the next cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffba_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ffba_pkg::IDX_W-1:0] i_idx,
    input  logic [ffba_pkg::CNT_W-1:0] i_count,
    input  logic [31:0]                i_req_size,
    input  logic [31:0]                i_req_addr,
    input  ffba_pkg::t_ffba_upd        i_upd,
    input  ffba_pkg::t_ffba_tok        i_tok,
    output ffba_pkg::t_ffba_tok        o_tok
);
    import ffba_pkg::*;

    logic [DATA_W-1:0] r_addr;
    logic [DATA_W-1:0] r_size;
    logic              r_free;
    t_ffba_tok         r_tok;
    t_ffba_tok         n_tok;
    logic              w_live;

    assign w_live = i_tok.vld && (CNT_W'(i_idx) < i_count);

    always_comb begin
        n_tok = i_tok;
        if (w_live && !i_tok.fit_hit && r_free && (r_size >= i_req_size)) begin
            n_tok.fit_hit  = 1'b1;
            n_tok.fit_idx  = i_idx;
            n_tok.fit_addr = r_addr;
        end
        if (w_live && !i_tok.lk_hit && (r_addr == i_req_addr)) begin
            n_tok.lk_hit  = 1'b1;
            n_tok.lk_idx  = i_idx;
            n_tok.lk_free = r_free;
            n_tok.lk_size = r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.app_en && (i_upd.app_idx == i_idx)) begin
            r_addr <= i_upd.app_addr;
            r_size <= i_upd.app_size;
            r_free <= 1'b0;
        end else if (i_upd.set_en && (i_upd.set_idx == i_idx)) begin
            r_free <= 1'b1;
        end else if (i_upd.clr_en && (i_upd.clr_idx == i_idx)) begin
            r_free <= 1'b0;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: hw/rtl/first_fit_block_allocator_core.sv
// ---------------------------------------------------------------------------
// First-fit block allocator core
// Block table held in a row of cells; one search item walks the row per
// request, then the table, heap top and result are updated.
// ---------------------------------------------------------------------------
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser req_type, tdata size+addr
// m_axis    out  m_axis_tvalid/m_axis_tready    tuser status, tdata address
// cfg       in   i_cfg_we                       i_cfg_wdata heap_limit
//
// The search item steps through the cell row one cell per cycle after accept,
// and the result is formed once it leaves the last cell.
// The next request can be taken in the cycle after the result is loaded.
// A stalled result holds the update stage; the output register then waits.
// Synchronous active-low reset clears the block count and heap top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_block_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] request_size, [63:32] block_address
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] result_address
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import ffba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state            r_state;
    logic              r_go;
    logic [1:0]        r_type;
    logic [DATA_W-1:0] r_size;
    logic [DATA_W-1:0] r_addr;
    logic [END_W-1:0]  r_end;
    logic [CNT_W-1:0]  r_count;
    logic [DATA_W-1:0] r_top;
    logic [DATA_W-1:0] r_limit;
    t_ffba_tok         r_res;
    logic              r_ovld;
    logic [DATA_W-1:0] r_oaddr;
    logic [1:0]        r_ost;

    t_ffba_tok         w_tok [0:MAX_BLOCKS];
    t_ffba_upd         w_upd;
    logic              w_accept;
    logic              w_fire;
    logic              w_is_alloc;
    logic              a_ok;
    logic              a_app;
    logic              a_clr;
    logic [DATA_W-1:0] a_addr;
    logic              w_commit;
    logic [DATA_W-1:0] n_res;
    logic [1:0]        n_st;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_fire        = (r_state == S_DONE) && (!r_ovld || m_axis_tready);

    always_comb begin
        w_tok[0]     = '0;
        w_tok[0].vld = r_go;
    end

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        ffba_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_idx      (IDX_W'(g)),
            .i_count    (r_count),
            .i_req_size (r_size),
            .i_req_addr (r_addr),
            .i_upd      (w_upd),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    always_comb begin
        w_is_alloc = (r_type == REQ_ALLOC) ||
                     ((r_type == REQ_REALLOC) && (r_addr == '0));
        a_ok   = 1'b0;
        a_app  = 1'b0;
        a_clr  = 1'b0;
        a_addr = r_top + DATA_W'(HEADER_BYTES);
        priority if (r_size == '0) begin
            a_ok = 1'b0;
        end else if (r_res.fit_hit) begin
            a_ok   = 1'b1;
            a_clr  = 1'b1;
            a_addr = r_res.fit_addr;
        end else if (r_count >= CNT_W'(MAX_BLOCKS)) begin
            a_ok = 1'b0;
        end else if (r_end > {2'b00, r_limit}) begin
            a_ok = 1'b0;
        end else begin
            a_ok  = 1'b1;
            a_app = 1'b1;
        end

        w_commit = 1'b0;
        n_res    = '0;
        n_st     = ST_OK;
        w_upd          = '0;
        w_upd.app_idx  = r_count[IDX_W-1:0];
        w_upd.app_addr = a_addr;
        w_upd.app_size = r_size;
        w_upd.clr_idx  = r_res.fit_idx;
        w_upd.set_idx  = r_res.lk_idx;

        priority if (w_is_alloc) begin
            w_commit = 1'b1;
            n_res    = a_ok ? a_addr : '0;
            n_st     = a_ok ? ST_OK : ST_FAIL;
        end else if (r_type == REQ_FREE) begin
            if (r_addr != '0) begin
                if (!r_res.lk_hit || r_res.lk_free) begin
                    n_st = ST_BAD;
                end else begin
                    w_upd.set_en = w_fire;
                end
            end
        end else if (r_type == REQ_REALLOC) begin
            priority if (!r_res.lk_hit || r_res.lk_free) begin
                n_st = ST_BAD;
            end else if (r_res.lk_size >= r_size) begin
                n_res = r_addr;
            end else if (a_ok) begin
                w_commit     = 1'b1;
                w_upd.set_en = w_fire;
                n_res        = a_addr;
            end else begin
                n_st = ST_FAIL;
            end
        end else begin
            n_st = ST_OK;
        end

        w_upd.app_en = w_fire && w_commit && a_ok && a_app;
        w_upd.clr_en = w_fire && w_commit && a_ok && a_clr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_go <= w_accept;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_tok[MAX_BLOCKS].vld) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_type <= s_axis_tuser;
            r_size <= s_axis_tdata[31:0];
            r_addr <= s_axis_tdata[63:32];
            r_end  <= {2'b00, r_top} + END_W'(HEADER_BYTES) +
                      {2'b00, s_axis_tdata[31:0]};
        end
        if ((r_state == S_SCAN) && w_tok[MAX_BLOCKS].vld) begin
            r_res <= w_tok[MAX_BLOCKS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_top   <= '0;
        end else if (w_upd.app_en) begin
            r_count <= r_count + CNT_W'(1);
            r_top   <= r_end[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= HEAP_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_fire) begin
            r_ovld <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_oaddr <= n_res;
            r_ost   <= n_st;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_oaddr;
    assign m_axis_tuser  = r_ost;

endmodule

// File: hw/rtl/ffba_chk.sv
// ---------------------------------------------------------------------------
// First-fit block allocator checker
// Port-level assertions on the allocator core, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "first_fit_block_allocator_core_defines.svh"

module ffba_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [31:0] result_address
    input  logic [1:0]  m_axis_tuser    // [1:0] status
);
    import ffba_pkg::*;

    `FFBA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "stalled result item changed")
    `FFBA_ASSERT_SAME(a_fail_null, m_axis_tvalid && (m_axis_tuser != ST_OK),
        m_axis_tdata == '0, "failed result item carries an address")
    `FFBA_ASSERT_NEXT(a_one_busy, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "new item taken while one is in flight")
    `FFBA_ASSERT_SAME(a_load_busy, $rose(m_axis_tvalid),
        !$past(s_axis_tready), "result item loaded while input was open")

endmodule

bind first_fit_block_allocator_core ffba_chk u_ffba_chk (.*);

// File: test/ffba_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// First-fit allocator result checker
// Watches the request, result and config channels, keeps its own copy of
// the block table and heap, predicts each granted address and status, and
// compares every result against the oldest prediction.
// ---------------------------------------------------------------------------

module ffba_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] request_size, [63:32] block_address
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [31:0] result_address
    input  logic [1:0]  m_axis_tuser,   // [1:0] status
    output int          o_outstanding,
    output int          o_failures
);
    import ffba_pkg::*;

    typedef struct packed {
        logic [31:0] addr;
        logic [1:0]  status;
    } t_grant;

    logic [31:0] blk_addr [MAX_BLOCKS];
    logic [31:0] blk_size [MAX_BLOCKS];
    logic        blk_free [MAX_BLOCKS];
    int unsigned blk_count  = 0;
    logic [31:0] heap_top   = '0;
    logic [31:0] heap_limit = HEAP_LIMIT_RST;

    t_grant grants_due[$];
    int     fault_count  = 0;
    int     results_seen = 0;

    assign o_failures = fault_count;

    function automatic int find_block(input logic [31:0] addr);
        for (int i = 0; i < blk_count; i++) begin
            if (blk_addr[i] == addr) begin
                return i;
            end
        end
        return -1;
    endfunction

    // First free block that fits, else append at the heap top.
    function automatic logic carve_block(input logic [31:0] size, output logic [31:0] addr);
        logic [33:0] heap_end;
        addr = '0;
        if (size == '0) begin
            return 1'b0;
        end
        for (int i = 0; i < blk_count; i++) begin
            if (blk_free[i] && blk_size[i] >= size) begin
                blk_free[i] = 1'b0;
                addr = blk_addr[i];
                return 1'b1;
            end
        end
        if (blk_count >= MAX_BLOCKS) begin
            return 1'b0;
        end
        heap_end = {2'b00, heap_top} + 34'(HEADER_BYTES) + {2'b00, size};
        if (heap_end > {2'b00, heap_limit}) begin
            return 1'b0;
        end
        blk_addr[blk_count] = heap_top + 32'(HEADER_BYTES);
        blk_size[blk_count] = size;
        blk_free[blk_count] = 1'b0;
        addr = blk_addr[blk_count];
        blk_count++;
        heap_top = heap_end[31:0];
        return 1'b1;
    endfunction

    function automatic t_grant serve_request(input logic [1:0] kind, input logic [31:0] size,
                                             input logic [31:0] addr);
        t_grant      g;
        int          idx;
        logic [31:0] naddr;
        g.addr   = '0;
        g.status = ST_OK;
        if (kind == REQ_ALLOC || (kind == REQ_REALLOC && addr == '0)) begin
            if (carve_block(size, naddr)) begin
                g.addr = naddr;
            end else begin
                g.status = ST_FAIL;
            end
        end else if (kind == REQ_FREE) begin
            if (addr != '0) begin
                idx = find_block(addr);
                if (idx < 0 || blk_free[idx]) begin
                    g.status = ST_BAD;
                end else begin
                    blk_free[idx] = 1'b1;
                end
            end
        end else if (kind == REQ_REALLOC) begin
            idx = find_block(addr);
            if (idx < 0 || blk_free[idx]) begin
                g.status = ST_BAD;
            end else if (blk_size[idx] >= size) begin
                g.addr = addr;
            end else if (carve_block(size, naddr)) begin
                blk_free[idx] = 1'b1;
                g.addr = naddr;
            end else begin
                g.status = ST_FAIL;
            end
        end
        return g;
    endfunction

    always @(posedge i_clk) begin
        t_grant want;
        t_grant got;
        if (!i_rst_n) begin
            blk_count  = 0;
            heap_top   = '0;
            heap_limit = HEAP_LIMIT_RST;
            grants_due.delete();
        end else begin
            if (i_cfg_we) begin
                heap_limit = i_cfg_wdata;
            end
            // Pop before push: a result always belongs to an earlier item.
            if (m_axis_tvalid && m_axis_tready) begin
                got.addr   = m_axis_tdata;
                got.status = m_axis_tuser;
                results_seen++;
                if (grants_due.size() == 0) begin
                    if (fault_count < 10) begin
                        $display("[%0t] result %0d with nothing outstanding: %s %h status %0d",
                                 $time, results_seen, "addr", got.addr, got.status);
                    end
                    fault_count++;
                end else begin
                    want = grants_due.pop_front();
                    if (got.addr !== want.addr || got.status !== want.status) begin
                        if (fault_count < 10) begin
                            $display("[%0t] result %0d: expected addr %h status %0d,",
                                     $time, results_seen, want.addr, want.status);
                            $display("    got addr %h status %0d",
                                     got.addr, got.status);
                        end
                        fault_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                grants_due.push_back(serve_request(s_axis_tuser, s_axis_tdata[31:0],
                                                   s_axis_tdata[63:32]));
            end
        end
        o_outstanding <= grants_due.size();
    end

endmodule

// File: test/tb_first_fit_block_allocator_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// First-fit allocator testbench
// Drives a directed request list and randomized allocate / free / reallocate
// traffic under several heap limits, with bursty requests and a stalling
// result side; the result checker predicts and compares every item.
// ---------------------------------------------------------------------------

module tb_first_fit_block_allocator_core;
    import ffba_pkg::*;

    localparam logic [1:0]  REQ_UNUSED = 2'd3;
    localparam logic [31:0] ADDR_A     = HEADER_BYTES;
    localparam logic [31:0] ADDR_B     = 2 * HEADER_BYTES + 1;
    localparam logic [31:0] ADDR_C     = 3 * HEADER_BYTES + 101;
    localparam logic [31:0] FILL_SIZE  = HEAP_LIMIT_RST - (4 * HEADER_BYTES + 301);

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [31:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int outstanding;
    int fault_total;

    logic [31:0] live_addrs[$];
    int burst_left = 0;
    int n_alloc = 0, n_free = 0, n_realloc = 0, n_unused = 0, n_limits = 1;
    int n_ok = 0, n_fail = 0, n_bad = 0;

    int results_taken = 0, hold_left = 0, style_cycles = 0, stall_style = 0, cycle_no = 0;
    bit hold_done = 1'b0;

    first_fit_block_allocator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ffba_result_checker result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_outstanding (outstanding),
        .o_failures    (fault_total)
    );

    always #5 i_clk = ~i_clk;

    // Keep granted addresses as targets for later free and reallocate items.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            case (m_axis_tuser)
                ST_OK:   n_ok++;
                ST_FAIL: n_fail++;
                default: n_bad++;
            endcase
            if (m_axis_tuser == ST_OK && m_axis_tdata != '0) begin
                live_addrs.push_back(m_axis_tdata);
                if (live_addrs.size() > 40) begin
                    live_addrs.delete(0);
                end
            end
        end
    end

    // Result side: changing stall styles plus one long hold-off.
    always @(posedge i_clk) begin
        cycle_no++;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_taken++;
            end
            if (style_cycles == 0) begin
                stall_style  = $urandom_range(0, 3);
                style_cycles = $urandom_range(20, 150);
            end
            style_cycles--;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && results_taken == 200) begin
                hold_done = 1'b1;
                hold_left = 400;
                m_axis_tready <= 1'b0;
            end else begin
                case (stall_style)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
                    2:       m_axis_tready <= (cycle_no % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    task automatic send_request(input logic [1:0] kind, input logic [31:0] size,
                                input logic [31:0] addr);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 90);
                default: gap = $urandom_range(1, 12);
            endcase
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {addr, size};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        case (kind)
            REQ_ALLOC:   n_alloc++;
            REQ_FREE:    n_free++;
            REQ_REALLOC: n_realloc++;
            default:     n_unused++;
        endcase
    endtask

    // Hold until every outstanding item has its result.
    task automatic drain_requests();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic set_heap_limit(input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        n_limits++;
    endtask

    function automatic logic [31:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)  return '0;
        if (roll < 55) return $urandom_range(1, 64);
        if (roll < 80) return $urandom_range(65, 4096);
        if (roll < 91) return $urandom_range(4097, 65536);
        if (roll < 93) return '1;
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_target();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return '0;
        if (live_addrs.size() != 0 && roll < 85) begin
            if (roll < 78) return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
            return live_addrs[$urandom_range(0, live_addrs.size() - 1)] + 32'd4;
        end
        return $urandom();
    endfunction

    task automatic random_request();
        int         roll;
        logic [1:0] kind;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            kind = REQ_ALLOC;
        end else if (roll < 65) begin
            kind = REQ_FREE;
        end else if (roll < 97) begin
            kind = REQ_REALLOC;
        end else begin
            kind = REQ_UNUSED;
        end
        send_request(kind, pick_size(), (kind == REQ_ALLOC) ? $urandom() : pick_target());
    endtask

    task automatic run_random(input int count);
        repeat (count) random_request();
        drain_requests();
    endtask

    initial begin
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(REQ_ALLOC,   32'd0,        32'd0);
        send_request(REQ_ALLOC,   32'd1,        32'd0);
        send_request(REQ_ALLOC,   '1,           32'd0);
        send_request(REQ_ALLOC,   32'd100,      32'd0);
        send_request(REQ_FREE,    32'd0,        32'd0);
        send_request(REQ_FREE,    32'd0,        '1);
        send_request(REQ_FREE,    32'd0,        ADDR_A);
        send_request(REQ_FREE,    32'd0,        ADDR_A);
        send_request(REQ_REALLOC, 32'd8,        ADDR_A);
        send_request(REQ_REALLOC, 32'd1,        32'd0);
        send_request(REQ_REALLOC, 32'd0,        ADDR_A);
        send_request(REQ_REALLOC, 32'd100,      ADDR_B);
        send_request(REQ_REALLOC, 32'd200,      ADDR_A);
        send_request(REQ_REALLOC, 32'd0,        32'd0);
        send_request(REQ_UNUSED,  '1,           '1);
        send_request(REQ_ALLOC,   32'd1,        32'd0);
        send_request(REQ_REALLOC, 32'd5,        32'h1234_5678);
        send_request(REQ_REALLOC, '1,           ADDR_C);
        send_request(REQ_FREE,    32'd0,        ADDR_B);
        send_request(REQ_ALLOC,   32'd50,       32'd0);
        send_request(REQ_FREE,    32'd0,        ADDR_C);
        send_request(REQ_FREE,    32'd0,        ADDR_A);
        send_request(REQ_ALLOC,   32'd150,      32'd0);
        send_request(REQ_ALLOC,   FILL_SIZE,    32'd0);
        send_request(REQ_ALLOC,   32'd1,        32'd0);
        drain_requests();

        set_heap_limit('0);
        run_random(100);
        set_heap_limit(HEAP_LIMIT_RST + $urandom_range(32'h1000, 32'h20000));
        run_random(200);
        set_heap_limit('1);
        run_random(200);
        set_heap_limit($urandom());
        run_random(175);

        repeat (MAX_BLOCKS + 8) @(posedge i_clk);
        $display("Sent %0d requests (%0d allocate, %0d free, %0d reallocate, %0d unused kind) under %0d heap limits.",
                 n_alloc + n_free + n_realloc + n_unused, n_alloc, n_free, n_realloc, n_unused,
                 n_limits);
        $display("Saw %0d ok, %0d failed and %0d invalid-address results, with one long result stall.",
                 n_ok, n_fail, n_bad);
        if (fault_total == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
